// ----- rtl/flash_command_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Flash command decoder assertion macros
// Concurrent assertion wrappers shared by the decoder RTL files.
// ----------------------------------------------------------------------------
`ifndef FLASH_COMMAND_DECODER_CORE_DEFINES_SVH
`define FLASH_COMMAND_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FCD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("flash command decoder check failed");
`define FCD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("flash command decoder check failed");
`else
`define FCD_ASSERT(name, clk, rst, prop)
`define FCD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- rtl/fcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash command decoder package
// Field widths, access and result codes, command words and the result type.
// ----------------------------------------------------------------------------
package fcd_pkg;

   localparam int AddrWidth     = 24;
   localparam int DataWidth     = 16;
   localparam int CmdWidth      = 2;
   localparam int KindWidth     = 3;
   localparam int CsrIndexWidth = 1;

   typedef enum logic [CmdWidth-1:0] {
      CMD_WRITE_WORD = 2'd0,
      CMD_READ_WORD  = 2'd1,
      CMD_READ_BYTE  = 2'd2
   } cmd_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_NONE       = 3'd0,
      KIND_PROGRAM    = 3'd1,
      KIND_ERASE      = 3'd2,
      KIND_READ_VALID = 3'd3,
      KIND_READ_ARRAY = 3'd4
   } kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MANUFACTURER_ID = 1'd0,
      CSR_DEVICE_ID       = 1'd1
   } csr_index_type;

   localparam logic [AddrWidth-1:0] UNLOCK_ADDR1     = 24'h00aaaa;
   localparam logic [AddrWidth-1:0] UNLOCK_ADDR2     = 24'h005554;
   localparam logic [AddrWidth-1:0] ID_ADDR_MFR      = 24'h000000;
   localparam logic [AddrWidth-1:0] ID_ADDR_DEV      = 24'h000002;
   localparam logic [DataWidth-1:0] UNLOCK_VAL1      = 16'haaaa;
   localparam logic [DataWidth-1:0] UNLOCK_VAL2      = 16'h5555;
   localparam logic [DataWidth-1:0] CMD_IDENTIFY     = 16'h9090;
   localparam logic [DataWidth-1:0] CMD_PROGRAM      = 16'ha0a0;
   localparam logic [DataWidth-1:0] CMD_ERASE        = 16'h8080;
   localparam logic [DataWidth-1:0] CMD_ERASE_SECTOR = 16'h3030;
   localparam logic [DataWidth-1:0] CMD_RESET        = 16'hf0f0;
   localparam logic [DataWidth-1:0] ERASE_VALUE      = 16'hffff;

   typedef struct packed {
      kind_type               kind;
      logic [AddrWidth-1:0]   op_addr;
      logic [DataWidth-1:0]   op_data;
   } result_type;

endpackage

// ----- rtl/fcd_req_if.sv -----
// ----------------------------------------------------------------------------
// Flash command decoder request channel
// Valid/ready channel carrying one bus access per transfer.
// ----------------------------------------------------------------------------
interface fcd_req_if
   import fcd_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CmdWidth-1:0]  cmd;
   logic [AddrWidth-1:0] addr;
   logic [DataWidth-1:0] wdata;

   modport source (output valid, output cmd, output addr, output wdata, input ready);
   modport sink   (input valid, input cmd, input addr, input wdata, output ready);
endinterface

// ----- rtl/fcd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Flash command decoder response channel
// Valid/ready channel carrying one decoded result per transfer.
// ----------------------------------------------------------------------------
interface fcd_rsp_if
   import fcd_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic [AddrWidth-1:0] op_addr;
   logic [DataWidth-1:0] op_data;

   modport source (output valid, output kind, output op_addr, output op_data, input ready);
   modport sink   (input valid, input kind, input op_addr, input op_data, output ready);
endinterface

// ----- rtl/flash_command_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Flash command decoder core
// Decodes JEDEC-style unlock and command sequences on a 16-bit flash bus.
// ----------------------------------------------------------------------------
// Each transfer on req_ch is one bus access: a word write, a word read or a
// byte read. Every access produces exactly one transfer on rsp_ch, in order,
// reporting a program-word or erase-sector operation, identify read data, a
// read that goes to the array, or nothing.
// The access is held in an input register, decoded against the command
// sequence state, and the result is held in an output register before it
// appears on rsp_ch. One access can be taken in every cycle while the
// receiver does not stall; the sequence state advances in the cycle the
// access moves from the input register to the output register.
// If the receiver stalls, the output register holds its result and the input
// register holds one further access; new requests are refused only when both
// are full. Reset returns the sequence to read-array mode, empties both
// registers and clears the identify words. The user must write the identify
// words on the csr port while no access is in flight; the core does not check.
// ----------------------------------------------------------------------------
`include "flash_command_decoder_core_defines.svh"

module flash_command_decoder_core
   import fcd_pkg::*;
#(
   parameter int ADDR_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   fcd_req_if.sink                  req_ch,
   fcd_rsp_if.source                rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]     csr_wdata
);

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [CmdWidth-1:0]  s1_cmd_ff;
   logic [AddrWidth-1:0] s1_addr_ff;
   logic [DataWidth-1:0] s1_wdata_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_result_ff;
   result_type           result;
   logic [DataWidth-1:0] mfr_id_ff;
   logic [DataWidth-1:0] dev_id_ff;
   logic                 rsp_free;
   logic                 advance;
   logic                 req_fire;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && rsp_free;
   assign req_ch.ready = !s1_valid_ff || rsp_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   fcd_decode #(
      .ADDR_BITS (ADDR_BITS)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (s1_cmd_ff),
      .addr   (s1_addr_ff),
      .wdata  (s1_wdata_ff),
      .mfr_id (mfr_id_ff),
      .dev_id (dev_id_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req_ch.cmd;
         s1_addr_ff  <= req_ch.addr;
         s1_wdata_ff <= req_ch.wdata;
      end
      if (advance) begin
         rsp_result_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mfr_id_ff <= '0;
         dev_id_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MANUFACTURER_ID: mfr_id_ff <= csr_wdata;
            CSR_DEVICE_ID:       dev_id_ff <= csr_wdata;
            default: begin
               mfr_id_ff <= mfr_id_ff;
            end
         endcase
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_result_ff.kind;
   assign rsp_ch.op_addr = rsp_result_ff.op_addr;
   assign rsp_ch.op_data = rsp_result_ff.op_data;

   `FCD_ASSERT(a_reset_empties, clock, reset,
      $past(reset) |-> !s1_valid_ff && !rsp_valid_ff)
   `FCD_ASSERT(a_no_overwrite, clock, reset,
      req_fire && s1_valid_ff |-> advance)
   `FCD_ASSERT(a_held_item_kept, clock, reset,
      s1_valid_ff && !advance |=> s1_valid_ff)
   `FCD_ASSERT(a_erase_value, clock, reset,
      rsp_valid_ff && rsp_result_ff.kind == KIND_ERASE |-> rsp_result_ff.op_data == ERASE_VALUE)

endmodule

// ----- rtl/fcd_decode.sv -----
// ----------------------------------------------------------------------------
// Flash command decoder sequencer
// Holds the unlock sequence state and decodes one bus access into a result.
// ----------------------------------------------------------------------------
`include "flash_command_decoder_core_defines.svh"

module fcd_decode
   import fcd_pkg::*;
#(
   parameter int ADDR_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [CmdWidth-1:0]  cmd,
   input  logic [AddrWidth-1:0] addr,
   input  logic [DataWidth-1:0] wdata,
   input  logic [DataWidth-1:0] mfr_id,
   input  logic [DataWidth-1:0] dev_id,
   output result_type           result
);

   localparam int UseBits = (ADDR_BITS < AddrWidth) ? ADDR_BITS : AddrWidth;
   localparam logic [AddrWidth-1:0] AddrMask = AddrWidth'((64'd1 << UseBits) - 64'd1);

   typedef enum logic [2:0] {
      PH_READ          = 3'd0,
      PH_UNLOCK1       = 3'd1,
      PH_UNLOCK2       = 3'd2,
      PH_IDENTIFY      = 3'd3,
      PH_PROGRAM       = 3'd4,
      PH_ERASE_UNLOCK1 = 3'd5,
      PH_ERASE_UNLOCK2 = 3'd6,
      PH_ERASE_CMD     = 3'd7
   } phase_type;

   phase_type            phase_ff;
   phase_type            phase_in;
   logic [AddrWidth-1:0] addr_m;
   logic [AddrWidth-1:0] id_addr;
   logic [DataWidth-1:0] id_word;
   logic                 at1;
   logic                 at2;

   assign addr_m = addr & AddrMask;
   assign at1    = (addr_m == UNLOCK_ADDR1);
   assign at2    = (addr_m == UNLOCK_ADDR2);

   always_comb begin
      id_addr = addr_m;
      if (cmd == CMD_READ_BYTE) begin
         id_addr[0] = 1'b0;
      end
      if (id_addr == ID_ADDR_MFR) begin
         id_word = mfr_id;
      end else if (id_addr == ID_ADDR_DEV) begin
         id_word = dev_id;
      end else begin
         id_word = '0;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      result.kind    = KIND_NONE;
      result.op_addr = '0;
      result.op_data = '0;
      case (cmd)
         CMD_WRITE_WORD: begin
            if (wdata == CMD_RESET && phase_ff != PH_PROGRAM) begin
               phase_in = PH_READ;
            end else begin
               case (phase_ff)
                  PH_READ, PH_IDENTIFY: begin
                     phase_in = (at1 && wdata == UNLOCK_VAL1) ? PH_UNLOCK1 : PH_READ;
                  end
                  PH_UNLOCK1: begin
                     phase_in = (at2 && wdata == UNLOCK_VAL2) ? PH_UNLOCK2 : PH_READ;
                  end
                  PH_UNLOCK2: begin
                     if (!at1) begin
                        phase_in = PH_READ;
                     end else if (wdata == CMD_IDENTIFY) begin
                        phase_in = PH_IDENTIFY;
                     end else if (wdata == CMD_PROGRAM) begin
                        phase_in = PH_PROGRAM;
                     end else if (wdata == CMD_ERASE) begin
                        phase_in = PH_ERASE_UNLOCK1;
                     end else begin
                        phase_in = PH_READ;
                     end
                  end
                  PH_PROGRAM: begin
                     phase_in       = PH_READ;
                     result.kind    = KIND_PROGRAM;
                     result.op_addr = addr_m;
                     result.op_data = wdata;
                  end
                  PH_ERASE_UNLOCK1: begin
                     phase_in = (at1 && wdata == UNLOCK_VAL1) ? PH_ERASE_UNLOCK2 : PH_READ;
                  end
                  PH_ERASE_UNLOCK2: begin
                     phase_in = (at2 && wdata == UNLOCK_VAL2) ? PH_ERASE_CMD : PH_READ;
                  end
                  default: begin
                     phase_in = PH_READ;
                     if (wdata == CMD_ERASE_SECTOR) begin
                        result.kind    = KIND_ERASE;
                        result.op_addr = addr_m;
                        result.op_data = ERASE_VALUE;
                     end
                  end
               endcase
            end
         end
         CMD_READ_WORD: begin
            if (phase_ff == PH_IDENTIFY) begin
               result.kind    = KIND_READ_VALID;
               result.op_data = id_word;
            end else begin
               result.kind = KIND_READ_ARRAY;
            end
         end
         CMD_READ_BYTE: begin
            if (phase_ff == PH_IDENTIFY) begin
               result.kind    = KIND_READ_VALID;
               result.op_data = addr_m[0] ? {8'h00, id_word[7:0]} : {8'h00, id_word[15:8]};
            end else begin
               result.kind = KIND_READ_ARRAY;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READ;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   `FCD_ASSERT(a_program_one_word, clock, reset,
      step && phase_ff == PH_PROGRAM && cmd == CMD_WRITE_WORD |=> phase_ff == PH_READ)
   `FCD_ASSERT(a_read_keeps_phase, clock, reset,
      step && cmd != CMD_WRITE_WORD |=> $stable(phase_ff))
   `FCD_ASSERT(a_erase_from_command, clock, reset,
      step && result.kind == KIND_ERASE |-> phase_ff == PH_ERASE_CMD)

endmodule
